// File: src/cmi_pkg.sv
`default_nettype none

package cmi_pkg;

  localparam int DATA_W     = 16;
  localparam int MAG_W      = 16;
  localparam int SUM_W      = 32;
  localparam int ROOT_STEPS = 16;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  // first test bit of the digit-by-digit root
  localparam logic [SUM_W-1:0] FIRST_BIT = 32'h4000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } cmi_state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic step;
    logic emit;
  } cmi_cmd_t;

endpackage

`default_nettype wire

// File: src/cmi_if.sv
`default_nettype none

interface cmi_in_if;
  import cmi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_real;
  logic signed [DATA_W-1:0] sample_imag;

  modport source (output valid, output sample_real, output sample_imag, input ready);
  modport sink (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface cmi_out_if;
  import cmi_pkg::*;

  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink (input valid, input magnitude, output ready);
endinterface

`default_nettype wire

// File: src/cmi_ctrl.sv
`default_nettype none

module cmi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              out_busy,
  output logic                   in_ready,
  output cmi_pkg::cmi_cmd_t      cmd
);
  import cmi_pkg::*;

  cmi_state_t        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square    = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the root until the output register is free
        if (!out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/cmi_dp.sv
`default_nettype none

module cmi_dp #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire cmi_pkg::cmi_cmd_t                cmd,
  input  wire logic signed [cmi_pkg::DATA_W-1:0] sample_real,
  input  wire logic signed [cmi_pkg::DATA_W-1:0] sample_imag,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [cmi_pkg::MAG_W-1:0]             magnitude,
  output logic                                  out_busy
);
  import cmi_pkg::*;

  localparam int SQ_W = 2 * SAMPLE_WIDTH;

  logic [SAMPLE_WIDTH-1:0] re_abs, im_abs;
  logic [SAMPLE_WIDTH-1:0] re_raw, im_raw;
  logic [SQ_W-1:0]         sq_re, sq_im;
  logic [SUM_W-1:0]        rem, root, test_bit;
  logic [SUM_W-1:0]        trial;

  // only the low sample bits count, negate when the sign bit is set
  assign re_raw = sample_real[SAMPLE_WIDTH-1:0];
  assign im_raw = sample_imag[SAMPLE_WIDTH-1:0];

  assign sq_re = re_abs * re_abs;
  assign sq_im = im_abs * im_abs;
  assign trial = root + test_bit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re_abs <= re_raw[SAMPLE_WIDTH-1] ? (~re_raw + 1'b1) : re_raw;
      im_abs <= im_raw[SAMPLE_WIDTH-1] ? (~im_raw + 1'b1) : im_raw;
    end
    if (cmd.square) begin
      rem      <= SUM_W'(sq_re) + SUM_W'(sq_im);
      root     <= '0;
      test_bit <= FIRST_BIT;
    end else if (cmd.step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + test_bit;
      end else begin
        root <= root >> 1;
      end
      test_bit <= test_bit >> 2;
    end
    if (cmd.emit) begin
      magnitude <= root[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

// File: src/complex_magnitude_isqrt.sv
// channel     dir   payload                        handshake
// sample_in   in    sample_real, sample_imag (s16) valid / ready
// result_out  out   magnitude (u16)                valid / ready
//
// one sample at a time: the sample is taken, then squared and summed,
// then 16 root steps run on a single compare-and-subtract unit, and then
// the output register is loaded with the result
// a new sample is taken while the previous result waits in the output register,
// the finished root then holds until that result is transferred
// rst is synchronous and clears the controller and the output valid flag

`default_nettype none

module complex_magnitude_isqrt #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  cmi_in_if.sink    sample_in,
  cmi_out_if.source result_out
);
  import cmi_pkg::*;

  cmi_cmd_t cmd;
  logic     out_busy;
  logic     in_ready;

  cmi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  cmi_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample_real (sample_in.sample_real),
    .sample_imag (sample_in.sample_imag),
    .out_ready   (result_out.ready),
    .out_valid   (result_out.valid),
    .magnitude   (result_out.magnitude),
    .out_busy    (out_busy)
  );

  assign sample_in.ready = in_ready;

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.square, cmd.step, cmd.emit}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(result_out.valid && !result_out.ready))
    else $error("result written over one not yet transferred");

  a_load_then_square: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.square)
    else $error("square step did not follow sample load");

endmodule

`default_nettype wire

// File: tb/complex_magnitude_isqrt_tb.sv
module complex_magnitude_isqrt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmi_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [MAG_W-1:0]         mag;
  } pending_mag_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cmi_in_if  sample_if ();
  cmi_out_if result_if ();

  complex_magnitude_isqrt #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_if),
    .result_out(result_if)
  );

  pending_mag_t expected_mags[$];
  bit           idle_on = 1'b1;
  int           samples_sent = 0;
  int           mags_checked = 0;
  int           mag_errors = 0;
  int           full_scale_hits = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor sqrt of re^2 + im^2, one root bit per step
  function automatic logic [MAG_W-1:0] predict_magnitude(logic [DATA_W-1:0] re,
                                                         logic [DATA_W-1:0] im);
    logic [SUM_W-1:0] span;
    logic [SUM_W-1:0] abs_re;
    logic [SUM_W-1:0] abs_im;
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] root;
    logic [SUM_W-1:0] probe;
    logic [SUM_W-1:0] trial;
    span   = SUM_W'(1) << SAMPLE_W;
    abs_re = SUM_W'(re) & (span - 1);
    abs_im = SUM_W'(im) & (span - 1);
    if (abs_re[SAMPLE_W-1]) abs_re = span - abs_re;
    if (abs_im[SAMPLE_W-1]) abs_im = span - abs_im;
    rem   = abs_re * abs_re + abs_im * abs_im;
    root  = '0;
    probe = FIRST_BIT;
    for (int i = 0; i < ROOT_STEPS; i++) begin
      trial = root + probe;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[MAG_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_part();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
      1: v = DATA_W'($urandom_range(32760, 32767));
      2: v = DATA_W'(-32768 + $urandom_range(0, 8));
      3: begin
        v = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      4: v = '0;
      default: v = DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // one sample transfer; valid stays high into the next call unless it idles
  task automatic send_sample(input logic signed [DATA_W-1:0] re,
                             input logic signed [DATA_W-1:0] im);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid       <= 1'b1;
    sample_if.sample_real <= re;
    sample_if.sample_imag <= im;
    do @(posedge clk); while (!sample_if.ready);
    expected_mags.push_back('{re: re, im: im, mag: predict_magnitude(re, im)});
    samples_sent++;
  endtask

  task automatic wait_for_drain();
    while (expected_mags.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, -16'sd32768);
    send_sample(16'sd0, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd3, 16'sd4);
    send_sample(-16'sd3, -16'sd4);
    send_sample(16'sd2, 16'sd1);
    send_sample(16'sd12, -16'sd5);
    send_sample(16'sh5555, -16'sh5556);
    send_sample(-16'sh5556, 16'sh5555);
    send_sample(16'sd181, 16'sd0);
    send_sample(-16'sd255, 16'sd256);
    send_sample(16'sd46, 16'sd30000);
  endtask

  task automatic test_random_full_range(input int count);
    for (int i = 0; i < count; i++)
      send_sample(DATA_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic test_random_corners(input int count);
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    for (int i = 0; i < count; i++) begin
      re = pick_part();
      im = pick_part();
      send_sample(re, im);
    end
  endtask

  // sender holds off until the pipeline is empty, then restarts
  task automatic test_drain_pauses(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i < 1 + r * 3; i++)
        send_sample(DATA_W'($urandom), DATA_W'($urandom));
      sample_if.valid <= 1'b0;
      wait_for_drain();
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_full_range(count / 2);
    test_random_corners(count - count / 2);
  endtask

  initial begin
    sample_if.valid       <= 1'b0;
    sample_if.sample_real <= '0;
    sample_if.sample_imag <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_full_range(680);
    test_random_corners(350);
    test_drain_pauses(8);
    test_back_to_back(300);

    sample_if.valid <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d samples sent, %0d magnitudes checked, %0d at full scale, %0d mismatches",
             samples_sent, mags_checked, full_scale_hits, mag_errors);
    $display("covered: extremes, zero, random and corner-biased parts, drains, back-to-back");
    if (mag_errors == 0 && expected_mags.size() == 0) begin
      $display("complex_magnitude_isqrt_tb: done, clean");
    end else begin
      $display("complex_magnitude_isqrt_tb: done, errors");
    end
    $finish;
  end

  // result side: random ready stalls and checking against the oldest prediction
  initial begin
    int           stall_left;
    pending_mag_t want;
    stall_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_if.ready <= 1'b0;
      end else begin
        if (result_if.valid && result_if.ready) begin
          if (expected_mags.size() == 0) begin
            if (mag_errors < 10)
              $display("unexpected magnitude %0d with nothing pending", result_if.magnitude);
            mag_errors++;
          end else begin
            want = expected_mags.pop_front();
            mags_checked++;
            if (want.mag == 16'd46340) full_scale_hits++;
            if (result_if.magnitude !== want.mag) begin
              if (mag_errors < 10)
                $display("magnitude mismatch re=%0d im=%0d: expected %0d, got %0d",
                         want.re, want.im, want.mag, result_if.magnitude);
              mag_errors++;
            end
          end
        end
        if (stall_left > 0) begin
          stall_left--;
          result_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(0, 11);
          result_if.ready <= 1'b0;
        end else begin
          result_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_mags.size());
    $display("complex_magnitude_isqrt_tb: done, errors");
    $finish;
  end

endmodule
